// ----- rtl/ddo_pkg.sv -----
// package: payload types, fixed widths, constants and helpers for the odometry block
package ddo_pkg;

  localparam int TICK_BITS = 14;
  localparam int MD_W = 80;
  localparam int MD_NW = $clog2(MD_W + 1);
  localparam int CS_W = 33;
  localparam int CZ_W = 26;
  localparam int ATAN_IDX_W = 5;
  localparam int SUM_W = 52;

  localparam logic [MD_W-1:0] HALF_K = 80'd87496355274;
  localparam logic [MD_W-1:0] RADIUS_LIMIT = 80'd70368744177663;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032875;
  localparam logic [15:0] HEADING_RESET = 16'd49152;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  localparam logic [1:0] OP_MOVE = 2'd0;
  localparam logic [1:0] OP_LEFT = 2'd1;
  localparam logic [1:0] OP_RIGHT = 2'd2;

  localparam logic [1:0] REG_TPI = 2'd0;
  localparam logic [1:0] REG_WB = 2'd1;
  localparam logic [1:0] REG_AO = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [TICK_BITS-1:0] left_ticks;
    logic [TICK_BITS-1:0] right_ticks;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [15:0] heading;
  } ddo_out_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TW_GO, S_TW_W, S_HN_GO, S_HN_W, S_HD_GO, S_HD_W,
    S_RN_GO, S_RN_W, S_RD_GO, S_RD_W, S_C1_GO, S_C1_W, S_CH_GO, S_CH_W,
    S_C2_GO, S_C2_W, S_DX_GO, S_DX_W, S_DY_GO, S_DY_W, S_DONE
  } state_t;

  function automatic logic signed [CZ_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      5'd0: v = 26'sd2097152;
      5'd1: v = 26'sd1238021;
      5'd2: v = 26'sd654136;
      5'd3: v = 26'sd332050;
      5'd4: v = 26'sd166669;
      5'd5: v = 26'sd83416;
      5'd6: v = 26'sd41718;
      5'd7: v = 26'sd20860;
      5'd8: v = 26'sd10430;
      5'd9: v = 26'sd5215;
      5'd10: v = 26'sd2608;
      5'd11: v = 26'sd1304;
      5'd12: v = 26'sd652;
      5'd13: v = 26'sd326;
      5'd14: v = 26'sd163;
      5'd15: v = 26'sd81;
      5'd16: v = 26'sd41;
      5'd17: v = 26'sd20;
      5'd18: v = 26'sd10;
      5'd19: v = 26'sd5;
      5'd20: v = 26'sd3;
      5'd21: v = 26'sd1;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/diff_drive_odometry.sv -----
// top level: odometry sequencer, configuration registers and result register
// a quarter turn or unused op goes from idle straight to the result state
// a move makes eight passes of the bit-serial multiply/divide unit
// (two 80-bit divisions, six products of 8 to 32 bits) and two cordic runs
// one transaction is worked at a time; input ready only while the sequencer is idle
// synchronous active-low reset: registers to defaults, position 8.0, 8.0, heading 49152
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ddo_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ddo_out_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int RSH = FRAC_BITS - 8;

  state_t state_r, state_nxt;
  logic [7:0] tpi_r;
  logic [15:0] wb_r, ao_r;
  logic signed [31:0] x_r, y_r;
  logic [15:0] hd_r, h_r;
  logic [TICK_BITS-1:0] diff_r, mn_r;
  logic left_r;
  logic [23:0] tw_r;
  logic [MD_W-1:0] num_r;
  logic [45:0] rq_r;
  logic [49:0] chord_r;
  logic chord_neg_r;
  logic sp_neg_r, cp_neg_r;
  logic [31:0] sp_mag_r, cp_mag_r;
  logic out_valid_r;
  ddo_out_t out_data_r;

  md_ctl_t md_ctl;
  logic [MD_W-1:0] md_a, md_b, md_res;
  logic [MD_NW-1:0] md_n;
  logic md_busy, md_done;
  logic cs_start, cs_busy, cs_done;
  logic [15:0] cs_ang;
  logic signed [CS_W-1:0] cs_sin, cs_cos;

  logic [7:0] tpi_e;
  logic [15:0] wb_e;
  logic [TICK_BITS-1:0] lt, rt, df;
  logic [MD_W-1:0] rsum;
  logic [49:0] pm;
  logic signed [SUM_W-1:0] pm_s, dd;
  logic [31:0] sh_mag;
  logic in_acc, out_load;

  assign tpi_e = (tpi_r == 8'd0) ? 8'd1 : tpi_r;
  assign wb_e = (wb_r == 16'd0) ? 16'd1 : wb_r;
  assign lt = in_data.left_ticks;
  assign rt = in_data.right_ticks;
  assign df = (lt > rt) ? lt - rt : rt - lt;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign rsum = md_res + (MD_W'(ao_r) << RSH);
  assign pm = md_res[79:30];
  assign pm_s = SUM_W'(signed'({1'b0, pm}));
  assign sh_mag = cs_sin[CS_W-1] ? 32'(-cs_sin) : 32'(cs_sin);

  ddo_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .ctl(md_ctl), .a(md_a), .b(md_b), .n(md_n),
    .busy(md_busy), .done(md_done), .res(md_res)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cs (
    .clk(clk), .rst_n(rst_n), .start(cs_start), .ang(cs_ang),
    .busy(cs_busy), .done(cs_done), .sin_o(cs_sin), .cos_o(cs_cos)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = (in_data.op == OP_MOVE) ? S_TW_GO : S_DONE;
      S_TW_GO: state_nxt = S_TW_W;
      S_TW_W: if (md_done) state_nxt = S_HN_GO;
      S_HN_GO: state_nxt = S_HN_W;
      S_HN_W: if (md_done) state_nxt = S_HD_GO;
      S_HD_GO: state_nxt = S_HD_W;
      S_HD_W: if (md_done) state_nxt = S_RN_GO;
      S_RN_GO: state_nxt = S_RN_W;
      S_RN_W: if (md_done) state_nxt = S_RD_GO;
      S_RD_GO: state_nxt = S_RD_W;
      S_RD_W: if (md_done) state_nxt = S_C1_GO;
      S_C1_GO: state_nxt = S_C1_W;
      S_C1_W: if (cs_done) state_nxt = S_CH_GO;
      S_CH_GO: state_nxt = S_CH_W;
      S_CH_W: if (md_done) state_nxt = S_C2_GO;
      S_C2_GO: state_nxt = S_C2_W;
      S_C2_W: if (cs_done) state_nxt = S_DX_GO;
      S_DX_GO: state_nxt = S_DX_W;
      S_DX_W: if (md_done) state_nxt = S_DY_GO;
      S_DY_GO: state_nxt = S_DY_W;
      S_DY_W: if (md_done) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    md_ctl = '0;
    md_a = '0;
    md_b = '0;
    md_n = '0;
    cs_start = 1'b0;
    cs_ang = h_r;
    case (state_r)
      S_TW_GO: begin
        md_ctl.start = 1'b1;
        md_a = MD_W'(wb_e);
        md_b = MD_W'(tpi_e);
        md_n = MD_NW'(8);
      end
      S_HN_GO: begin
        md_ctl.start = 1'b1;
        md_a = HALF_K;
        md_b = MD_W'(diff_r);
        md_n = MD_NW'(TICK_BITS);
      end
      S_HD_GO: begin
        md_ctl.start = 1'b1;
        md_ctl.is_div = 1'b1;
        md_a = num_r;
        md_b = MD_W'(tw_r) << 16;
        md_n = MD_NW'(MD_W);
      end
      S_RN_GO: begin
        md_ctl.start = 1'b1;
        md_a = MD_W'(wb_e);
        md_b = MD_W'(mn_r);
        md_n = MD_NW'(TICK_BITS);
      end
      S_RD_GO: begin
        md_ctl.start = 1'b1;
        md_ctl.is_div = 1'b1;
        md_a = num_r;
        md_b = MD_W'(diff_r);
        md_n = MD_NW'(MD_W);
      end
      S_C1_GO: begin
        cs_start = 1'b1;
        cs_ang = h_r;
      end
      S_CH_GO: begin
        md_ctl.start = 1'b1;
        md_a = MD_W'(rq_r);
        md_b = MD_W'(sp_mag_r);
        md_n = MD_NW'(32);
      end
      S_C2_GO: begin
        cs_start = 1'b1;
        cs_ang = left_r ? hd_r + h_r : hd_r - h_r;
      end
      S_DX_GO: begin
        md_ctl.start = 1'b1;
        md_a = MD_W'(chord_r);
        md_b = MD_W'(sp_mag_r);
        md_n = MD_NW'(32);
      end
      S_DY_GO: begin
        md_ctl.start = 1'b1;
        md_a = MD_W'(chord_r);
        md_b = MD_W'(cp_mag_r);
        md_n = MD_NW'(32);
      end
      default: begin
        md_ctl = '0;
      end
    endcase
  end

  always_comb begin
    dd = pm_s;
    if (state_r == S_DX_W) begin
      dd = (chord_neg_r ^ sp_neg_r) ? pm_s : -pm_s;
    end else begin
      dd = (chord_neg_r ^ cp_neg_r) ? -pm_s : pm_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tpi_r <= 8'd25;
      wb_r <= 16'd1600;
      ao_r <= 16'd832;
      x_r <= 32'(8 << FRAC_BITS);
      y_r <= 32'(8 << FRAC_BITS);
      hd_r <= HEADING_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TPI: tpi_r <= cfg_wdata[7:0];
          REG_WB: wb_r <= cfg_wdata;
          REG_AO: ao_r <= cfg_wdata;
          default: tpi_r <= tpi_r;
        endcase
      end
      if (in_acc) begin
        case (in_data.op)
          OP_LEFT: hd_r <= hd_r + QUARTER_TURN;
          OP_RIGHT: hd_r <= hd_r - QUARTER_TURN;
          default: hd_r <= hd_r;
        endcase
      end
      if (state_r == S_DX_W && md_done) begin
        x_r <= sat32(SUM_W'(x_r) + dd);
      end
      if (state_r == S_DY_W && md_done) begin
        y_r <= sat32(SUM_W'(y_r) + dd);
        hd_r <= left_r ? hd_r + {h_r[14:0], 1'b0} : hd_r - {h_r[14:0], 1'b0};
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r <= (df == '0) ? TICK_BITS'(1) : df;
      mn_r <= (lt < rt) ? lt : rt;
      left_r <= lt < rt;
    end
    if (state_r == S_TW_W && md_done) tw_r <= md_res[23:0];
    if (state_r == S_HN_W && md_done) num_r <= md_res + (MD_W'(tw_r) << 15);
    if (state_r == S_HD_W && md_done) h_r <= md_res[15:0];
    if (state_r == S_RN_W && md_done) num_r <= md_res << RSH;
    if (state_r == S_RD_W && md_done) begin
      rq_r <= (rsum > RADIUS_LIMIT) ? RADIUS_LIMIT[45:0] : rsum[45:0];
    end
    if (state_r == S_C1_W && cs_done) begin
      sp_mag_r <= sh_mag;
      sp_neg_r <= cs_sin[CS_W-1];
    end
    if (state_r == S_CH_W && md_done) begin
      chord_r <= md_res[78:29];
      chord_neg_r <= sp_neg_r;
    end
    if (state_r == S_C2_W && cs_done) begin
      sp_mag_r <= sh_mag;
      sp_neg_r <= cs_sin[CS_W-1];
      cp_mag_r <= cs_cos[CS_W-1] ? 32'(-cs_cos) : 32'(cs_cos);
      cp_neg_r <= cs_cos[CS_W-1];
    end
    if (out_load) begin
      out_data_r.x_pos <= x_r;
      out_data_r.y_pos <= y_r;
      out_data_r.heading <= hd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef NO_ASSERTIONS
  a_md_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_ctl.start |-> !md_busy) else $error("multiply/divide started while busy");
  a_cs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cs_start |-> !cs_busy) else $error("cordic started while busy");
  a_turn_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op != OP_MOVE) |=> state_r == S_DONE)
    else $error("non-move transaction did not go straight to result");
  a_x_upd: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(x_r)) |-> $past(state_r) == S_DX_W)
    else $error("x position changed outside its update step");
  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("result overwritten before delivery");
`endif

endmodule

// ----- rtl/ddo_muldiv.sv -----
// shared shift-add multiplier and restoring divider, one bit per cycle
module ddo_muldiv import ddo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  md_ctl_t ctl,
  input  logic [MD_W-1:0] a,
  input  logic [MD_W-1:0] b,
  input  logic [MD_NW-1:0] n,
  output logic busy,
  output logic done,
  output logic [MD_W-1:0] res
);

  logic busy_r, done_r, is_div_r;
  logic [MD_NW-1:0] cnt_r, n_r;
  logic [MD_W-1:0] acc_r, ma_r, mb_r;
  logic [MD_W:0] t;
  logic [MD_W+1:0] sub;

  assign t = {acc_r, ma_r[MD_W-1]};
  assign sub = {1'b0, t} - {2'b00, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == n_r - MD_NW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_div_r <= ctl.is_div;
      n_r <= n;
      cnt_r <= '0;
      acc_r <= '0;
      ma_r <= a;
      mb_r <= b;
    end else if (busy_r) begin
      cnt_r <= cnt_r + MD_NW'(1);
      if (is_div_r) begin
        if (!sub[MD_W+1]) begin
          acc_r <= sub[MD_W-1:0];
          ma_r <= {ma_r[MD_W-2:0], 1'b1};
        end else begin
          acc_r <= t[MD_W-1:0];
          ma_r <= {ma_r[MD_W-2:0], 1'b0};
        end
      end else begin
        if (mb_r[0]) begin
          acc_r <= acc_r + ma_r;
        end
        ma_r <= {ma_r[MD_W-2:0], 1'b0};
        mb_r <= {1'b0, mb_r[MD_W-1:1]};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res = is_div_r ? ma_r : acc_r;

endmodule

// ----- rtl/ddo_cordic.sv -----
// iterative rotation-mode cordic for sine and cosine of a binary angle
module ddo_cordic import ddo_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [15:0] ang,
  output logic busy,
  output logic done,
  output logic signed [CS_W-1:0] sin_o,
  output logic signed [CS_W-1:0] cos_o
);

  localparam int CNT_W = $clog2(STEPS);

  logic busy_r, done_r, flip_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [CS_W-1:0] x_r, y_r;
  logic signed [CZ_W-1:0] z_r;
  logic flip;
  logic [15:0] a_f, a_q;
  logic signed [CS_W-1:0] sx, sy;
  logic signed [CZ_W-1:0] at;

  assign a_q = ang + QUARTER_TURN;
  assign flip = a_q[15];
  assign a_f = flip ? {~ang[15], ang[14:0]} : ang;
  assign sx = y_r >>> cnt_r;
  assign sy = x_r >>> cnt_r;
  assign at = atan_val(ATAN_IDX_W'(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      cnt_r <= '0;
      x_r <= CORDIC_GAIN;
      y_r <= '0;
      z_r <= {{(CZ_W-24){a_f[15]}}, a_f, 8'd0};
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (!z_r[CZ_W-1]) begin
        x_r <= x_r - sx;
        y_r <= y_r + sy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + sx;
        y_r <= y_r - sy;
        z_r <= z_r + at;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign sin_o = flip_r ? -y_r : y_r;
  assign cos_o = flip_r ? -x_r : x_r;

endmodule
